// ----- sv/nps_pkg.sv -----
// shared types and field widths for the non-preemptive priority scheduler
package nps_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 12;
  localparam int TIME_W  = 16;
  localparam int COUNT_W = 5;

  // one input beat: one tick, possibly with a new job
  typedef struct packed {
    logic               arrive_valid;
    logic [ID_W-1:0]    arrive_id;
    logic [PRIO_W-1:0]  arrive_priority;
    logic [BURST_W-1:0] arrive_burst;
  } nps_in_t;

  // one result beat per tick
  typedef struct packed {
    logic               busy_res;
    logic [ID_W-1:0]    running_id;
    logic [BURST_W-1:0] running_remaining;
    logic               done_valid;
    logic [ID_W-1:0]    done_id;
    logic [TIME_W-1:0]  done_wait;
    logic [TIME_W-1:0]  done_turnaround;
    logic               arrival_dropped;
    logic [COUNT_W-1:0] queue_count;
  } nps_out_t;

  // one job as held in the ready queue or in the run slot
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
  } nps_job_t;

endpackage

// ----- sv/nps_qram.sv -----
// ready queue storage: one write port, one read port, registered read data
module nps_qram
  import nps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  nps_job_t       wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output nps_job_t       rd_data
);

  nps_job_t mem [DEPTH];
  nps_job_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/nonpreemptive_priority_scheduler.sv -----
// top level: tick-driven non-preemptive priority scheduler over a ring-buffer ready queue
// after start, busy stays high while the tick is in progress, until the out_valid strobe
// a tick passes through idle, arrive and finish, plus a load state when a job is reloaded from the queue,
// plus a scan state per queued job that an ordered insert shifts and a scan or put state to place it
// one result beat per tick, shown for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset empties the queue, idles the run slot and clears the tick count
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  nps_in_t  in_data,
  output logic     out_valid,
  output nps_out_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ARRIVE,
    S_SCAN,
    S_PUT,
    S_FIN
  } state_t;

  // ring position of logical queue slot k (head plus k below twice the depth)
  function automatic addr_t phys(input addr_t head, input logic [AW:0] k);
    logic [AW:0] sum;
    sum = {1'b0, head} + k;
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic addr_t ptr_inc(input addr_t p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic addr_t ptr_dec(input addr_t p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // control and run-slot state
  state_t             state_r, state_nxt;
  nps_in_t            in_r, in_nxt;
  logic [TIME_W-1:0]  tick_r, tick_nxt;
  logic               run_valid_r, run_valid_nxt;
  logic               run_started_r, run_started_nxt;
  nps_job_t           run_job_r, run_job_nxt;
  logic [BURST_W-1:0] run_rem_r, run_rem_nxt;
  addr_t              head_r, head_nxt;
  cnt_t               qlen_r, qlen_nxt;
  addr_t              scan_r, scan_nxt;

  // per-tick report
  logic               done_r, done_nxt;
  logic [ID_W-1:0]    d_id_r, d_id_nxt;
  logic [TIME_W-1:0]  d_wait_r, d_wait_nxt;
  logic [TIME_W-1:0]  d_turn_r, d_turn_nxt;
  logic               drop_r, drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  nps_out_t           out_r, out_nxt;

  // queue port
  logic     wr_en;
  addr_t    wr_addr;
  nps_job_t wr_data;
  logic     rd_en;
  addr_t    rd_addr;
  nps_job_t rd_data;

  // helpers
  nps_job_t           arr_job;
  logic [BURST_W-1:0] rem_dec;

  nps_qram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_qram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the arriving job, stamped with the current tick
  always_comb begin
    arr_job.id      = in_r.arrive_id;
    arr_job.prio    = in_r.arrive_priority;
    arr_job.burst   = in_r.arrive_burst;
    arr_job.arrival = tick_r;
  end

  // remaining burst after this tick's service; saturates at zero
  assign rem_dec = (run_valid_r && run_started_r && (run_rem_r != '0)) ?
                   run_rem_r - 1'b1 : run_rem_r;

  always_comb begin
    state_nxt       = state_r;
    in_nxt          = in_r;
    tick_nxt        = tick_r;
    run_valid_nxt   = run_valid_r;
    run_started_nxt = run_started_r;
    run_job_nxt     = run_job_r;
    run_rem_nxt     = run_rem_r;
    head_nxt        = head_r;
    qlen_nxt        = qlen_r;
    scan_nxt        = scan_r;
    done_nxt        = done_r;
    d_id_nxt        = d_id_r;
    d_wait_nxt      = d_wait_r;
    d_turn_nxt      = d_turn_r;
    drop_nxt        = drop_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    wr_en           = 1'b0;
    wr_addr         = head_r;
    wr_data         = arr_job;
    rd_en           = 1'b0;
    rd_addr         = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt     = in_data;
          done_nxt   = 1'b0;
          d_id_nxt   = '0;
          d_wait_nxt = '0;
          d_turn_nxt = '0;
          drop_nxt   = 1'b0;
          state_nxt  = S_ARRIVE;
          if (run_valid_r && (rem_dec == '0)) begin
            // completion: report and free the run slot
            done_nxt        = 1'b1;
            d_id_nxt        = run_job_r.id;
            d_turn_nxt      = tick_r - run_job_r.arrival;
            d_wait_nxt      = tick_r - TIME_W'(run_job_r.burst) - run_job_r.arrival;
            run_valid_nxt   = 1'b0;
            run_started_nxt = 1'b0;
            run_rem_nxt     = '0;
            if (qlen_r != '0) begin
              // fetch the queue head for reload
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = S_LOAD;
            end
          end else begin
            run_rem_nxt = rem_dec;
          end
        end
      end

      S_LOAD: begin
        run_valid_nxt   = 1'b1;
        run_started_nxt = 1'b0;
        run_job_nxt     = rd_data;
        run_rem_nxt     = rd_data.burst;
        head_nxt        = ptr_inc(head_r);
        qlen_nxt        = qlen_r - 1'b1;
        state_nxt       = S_ARRIVE;
      end

      S_ARRIVE: begin
        state_nxt = S_FIN;
        if (in_r.arrive_valid) begin
          if (!run_valid_r) begin
            run_valid_nxt   = 1'b1;
            run_started_nxt = 1'b0;
            run_job_nxt     = arr_job;
            run_rem_nxt     = arr_job.burst;
          end else if (qlen_r >= CW'(QUEUE_DEPTH)) begin
            drop_nxt = 1'b1;
          end else if (!run_started_r && (in_r.arrive_priority < run_job_r.prio)) begin
            // displaced job goes back to the front of the queue
            wr_en           = 1'b1;
            wr_addr         = ptr_dec(head_r);
            wr_data         = run_job_r;
            head_nxt        = ptr_dec(head_r);
            qlen_nxt        = qlen_r + 1'b1;
            run_valid_nxt   = 1'b1;
            run_started_nxt = 1'b0;
            run_job_nxt     = arr_job;
            run_rem_nxt     = arr_job.burst;
          end else if (qlen_r == '0) begin
            wr_en    = 1'b1;
            wr_addr  = head_r;
            qlen_nxt = qlen_r + 1'b1;
          end else begin
            // walk back from the tail, shifting worse-priority jobs down
            rd_en     = 1'b1;
            rd_addr   = phys(head_r, (AW+1)'(qlen_r - 1'b1));
            scan_nxt  = AW'(qlen_r - 1'b1);
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, {1'b0, scan_r} + 1'b1);
        if (rd_data.prio > in_r.arrive_priority) begin
          wr_data = rd_data;
          if (scan_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = phys(head_r, {1'b0, scan_r} - 1'b1);
            scan_nxt = scan_r - 1'b1;
          end
        end else begin
          qlen_nxt  = qlen_r + 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        qlen_nxt  = qlen_r + 1'b1;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        run_started_nxt           = run_valid_r;
        tick_nxt                  = tick_r + 1'b1;
        out_valid_nxt             = 1'b1;
        out_nxt.busy_res          = run_valid_r;
        out_nxt.running_id        = run_valid_r ? run_job_r.id : '0;
        out_nxt.running_remaining = run_valid_r ? run_rem_r : '0;
        out_nxt.done_valid        = done_r;
        out_nxt.done_id           = d_id_r;
        out_nxt.done_wait         = d_wait_r;
        out_nxt.done_turnaround   = d_turn_r;
        out_nxt.arrival_dropped   = drop_r;
        out_nxt.queue_count       = COUNT_W'(qlen_r);
        state_nxt                 = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_r        <= '0;
      run_valid_r   <= 1'b0;
      run_started_r <= 1'b0;
      run_job_r     <= '0;
      run_rem_r     <= '0;
      head_r        <= '0;
      qlen_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      tick_r        <= tick_nxt;
      run_valid_r   <= run_valid_nxt;
      run_started_r <= run_started_nxt;
      run_job_r     <= run_job_nxt;
      run_rem_r     <= run_rem_nxt;
      head_r        <= head_nxt;
      qlen_r        <= qlen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    scan_r   <= scan_nxt;
    done_r   <= done_nxt;
    d_id_r   <= d_id_nxt;
    d_wait_r <= d_wait_nxt;
    d_turn_r <= d_turn_nxt;
    drop_r   <= drop_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
